// ===== rtl/core/sfr_pkg.sv =====
// Shared types and constants for the stuffed frame receiver.
package sfr_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_HEAD_MARKER   = 2'd0;
   localparam logic [1:0] CSR_END_MARKER    = 2'd1;
   localparam logic [1:0] CSR_ESCAPE_MARKER = 2'd2;
   localparam logic [1:0] CSR_ACK_COMMAND   = 2'd3;

   // Second byte of an escape pair and what it stands for.
   localparam logic [7:0] SUFFIX_HEAD = 8'hA3;
   localparam logic [7:0] SUFFIX_END  = 8'hA2;
   localparam logic [7:0] SUFFIX_ESC  = 8'hA1;

   localparam logic [7:0] BAD_CODE = 8'hFF;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Classification of one received byte after unstuffing.
   typedef struct packed {
      logic       head;
      logic       fin;
      logic       data;
      logic [7:0] value;
   } decode_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [7:0]  command;
      logic [7:0]  payload_length;
      logic [7:0]  result_code;
      logic        checksum_ok;
      logic [15:0] peer_address;
   } result_type;

endpackage

// ===== rtl/core/sfr_decode.sv =====
// Escape removal and marker classification of the received bytes.
module sfr_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          rx_byte,
   input  logic [7:0]          head_marker,
   input  logic [7:0]          end_marker,
   input  logic [7:0]          escape_marker,
   output sfr_pkg::decode_type dec
);

   logic escape_pending_ff;
   logic escape_pending_in;
   logic is_suffix;
   logic raw_path;

   always_comb begin
      is_suffix = (rx_byte == sfr_pkg::SUFFIX_HEAD) || (rx_byte == sfr_pkg::SUFFIX_END) ||
                  (rx_byte == sfr_pkg::SUFFIX_ESC);
      // A pending escape followed by anything but a suffix is dropped, and the
      // byte is then handled as if no escape had come before it.
      raw_path = !escape_pending_ff || !is_suffix;

      dec.head  = 1'b0;
      dec.fin   = 1'b0;
      dec.data  = 1'b0;
      dec.value = rx_byte;
      escape_pending_in = 1'b0;

      if (!raw_path) begin
         dec.data = 1'b1;
         unique case (rx_byte)
            sfr_pkg::SUFFIX_HEAD: dec.value = head_marker;
            sfr_pkg::SUFFIX_END:  dec.value = end_marker;
            default:              dec.value = escape_marker;
         endcase
      end else begin
         priority if (rx_byte == head_marker) begin
            dec.head = 1'b1;
         end else if (rx_byte == end_marker) begin
            dec.fin = 1'b1;
         end else if (rx_byte == escape_marker) begin
            escape_pending_in = 1'b1;
         end else begin
            dec.data = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
      end else if (advance) begin
         escape_pending_ff <= escape_pending_in;
      end
   end

endmodule

// ===== rtl/core/sfr_frame.sv =====
// Frame parser: phase tracking, checksum, payload output and peer address latch.
module sfr_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  sfr_pkg::decode_type dec,
   input  logic [7:0]          ack_command,
   output logic                res_valid,
   output sfr_pkg::result_type res
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CMD,
      PH_LEN,
      PH_PAY,
      PH_SHI,
      PH_SLO,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  sum_high_ff, sum_high_in;
   logic [7:0]  sum_low_ff, sum_low_in;
   logic [15:0] candidate_ff, candidate_in;
   logic [15:0] peer_ff, peer_in;
   logic        sum_match;
   logic [7:0]  count_next;

   assign sum_match  = ({sum_high_ff, sum_low_ff} == sum_ff);
   assign count_next = count_ff + 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      command_in   = command_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sum_high_in  = sum_high_ff;
      sum_low_in   = sum_low_ff;
      candidate_in = candidate_ff;
      peer_in      = peer_ff;
      res_valid    = 1'b0;

      res.kind           = sfr_pkg::KIND_DATA;
      res.data_byte      = 8'd0;
      res.byte_index     = 8'd0;
      res.command        = command_ff;
      res.payload_length = length_ff;
      res.result_code    = 8'd0;
      res.checksum_ok    = 1'b0;
      res.peer_address   = peer_ff;

      if (dec.head) begin
         // A head always restarts, dropping any frame in progress unreported.
         phase_in     = PH_CMD;
         command_in   = 8'd0;
         length_in    = 8'd0;
         count_in     = 8'd0;
         sum_in       = {8'd0, dec.value};
         sum_high_in  = 8'd0;
         sum_low_in   = 8'd0;
         candidate_in = 16'd0;
      end else if (dec.fin) begin
         if (phase_ff != PH_IDLE) begin
            res_valid    = 1'b1;
            res.kind     = sfr_pkg::KIND_SUMMARY;
            res.result_code = sfr_pkg::BAD_CODE;
            if (phase_ff == PH_DONE && sum_match) begin
               res.result_code = command_ff;
               res.checksum_ok = 1'b1;
               if (command_ff == ack_command && length_ff >= 8'd2) begin
                  peer_in = candidate_ff;
               end
            end
            res.peer_address = peer_in;
            phase_in = PH_IDLE;
         end
      end else if (dec.data) begin
         unique case (phase_ff)
            PH_CMD: begin
               command_in = dec.value;
               sum_in     = sum_ff + {8'd0, dec.value};
               phase_in   = PH_LEN;
            end
            PH_LEN: begin
               length_in = dec.value;
               sum_in    = sum_ff + {8'd0, dec.value};
               count_in  = 8'd0;
               phase_in  = (dec.value == 8'd0) ? PH_SHI : PH_PAY;
            end
            PH_PAY: begin
               res_valid      = 1'b1;
               res.data_byte  = dec.value;
               res.byte_index = count_ff;
               sum_in         = sum_ff + {8'd0, dec.value};
               if (count_ff == 8'd0) begin
                  candidate_in = {candidate_ff[15:8], dec.value};
               end else if (count_ff == 8'd1) begin
                  candidate_in = {dec.value, candidate_ff[7:0]};
               end
               count_in = count_next;
               if (count_next == length_ff) begin
                  phase_in = PH_SHI;
               end
            end
            PH_SHI: begin
               sum_high_in = dec.value;
               phase_in    = PH_SLO;
            end
            PH_SLO: begin
               sum_low_in = dec.value;
               phase_in   = PH_DONE;
            end
            default: begin
               // Idle or after the checksum: data is ignored.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         command_ff   <= 8'd0;
         length_ff    <= 8'd0;
         count_ff     <= 8'd0;
         sum_ff       <= 16'd0;
         sum_high_ff  <= 8'd0;
         sum_low_ff   <= 8'd0;
         candidate_ff <= 16'd0;
         peer_ff      <= 16'd0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         command_ff   <= command_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sum_high_ff  <= sum_high_in;
         sum_low_ff   <= sum_low_in;
         candidate_ff <= candidate_in;
         peer_ff      <= peer_in;
      end
   end

endmodule

// ===== rtl/core/stuffed_frame_receiver.sv =====
// Top level of the stuffed frame receiver: registers, handshakes and configuration.
//
// Raw line bytes enter on the req_ channel; each item is one received byte.
// Escape pairs are removed, frames of head, command, length, payload and a
// 16-bit checksum (high byte first) are parsed, and results leave on the
// rsp_ channel: one item per payload byte (kind 0) and one summary per frame
// end (kind 1, result code 255 on a bad or incomplete checksum). Bytes that
// only move the parser along produce no result.
// The csr_ port writes the head, end and escape markers and the ack command;
// the user must write it only while no item is in flight, as the block itself
// does not enforce this. The byte waits in the input register while the decode
// and parse logic feeds the result register, which drives rsp_valid.
// Throughput is one item per cycle while rsp_ready keeps the result register
// free, set by the single parse step per byte.
// When the receiver holds rsp_ready low, a finished result stays in the
// result register and one further byte waits in the input register before
// req_ready falls. Reset clears all parser state, the peer address and the
// configuration registers to zero.
module stuffed_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_byte_index,
   output logic [7:0]  rsp_command,
   output logic [7:0]  rsp_payload_length,
   output logic [7:0]  rsp_result_code,
   output logic        rsp_checksum_ok,
   output logic [15:0] rsp_peer_address,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                rsp_valid_ff;
   sfr_pkg::result_type rsp_ff;
   logic [7:0]          head_marker_ff;
   logic [7:0]          end_marker_ff;
   logic [7:0]          escape_marker_ff;
   logic [7:0]          ack_command_ff;

   logic                out_free;
   logic                advance;
   sfr_pkg::decode_type dec;
   logic                res_valid;
   sfr_pkg::result_type res;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   sfr_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .rx_byte       (in_byte_ff),
      .head_marker   (head_marker_ff),
      .end_marker    (end_marker_ff),
      .escape_marker (escape_marker_ff),
      .dec           (dec)
   );

   sfr_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .dec         (dec),
      .ack_command (ack_command_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= advance && res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_marker_ff   <= 8'd0;
         end_marker_ff    <= 8'd0;
         escape_marker_ff <= 8'd0;
         ack_command_ff   <= 8'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            sfr_pkg::CSR_HEAD_MARKER:   head_marker_ff   <= csr_wdata;
            sfr_pkg::CSR_END_MARKER:    end_marker_ff    <= csr_wdata;
            sfr_pkg::CSR_ESCAPE_MARKER: escape_marker_ff <= csr_wdata;
            sfr_pkg::CSR_ACK_COMMAND:   ack_command_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_byte_index     = rsp_ff.byte_index;
   assign rsp_command        = rsp_ff.command;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_result_code    = rsp_ff.result_code;
   assign rsp_checksum_ok    = rsp_ff.checksum_ok;
   assign rsp_peer_address   = rsp_ff.peer_address;

endmodule
